### src/rigid_point_transform_assert.svh
// Assertion macros for the rigid point transform.
// Each macro expects clk and rst_n to exist in the scope where it is used.
`ifndef RIGID_POINT_TRANSFORM_ASSERT_SVH
`define RIGID_POINT_TRANSFORM_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define RPT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rigid_point_transform: check failed");

// Next-cycle implication.
`define RPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rigid_point_transform: check failed");

`else

`define RPT_ASSERT_SAME(lbl, ante, cons)
`define RPT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### src/rpt_pkg.sv
`timescale 1ns / 1ps

package rpt_pkg;

    localparam int FIELD_W = 32;
    localparam int CFG_W   = 48;
    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 64;

    typedef logic [2:0] rpt_reg_idx_t;

    localparam rpt_reg_idx_t REG_ROT_ROW0 = 3'd0;
    localparam rpt_reg_idx_t REG_ROT_ROW1 = 3'd1;
    localparam rpt_reg_idx_t REG_ROT_ROW2 = 3'd2;
    localparam rpt_reg_idx_t REG_TRANS_X  = 3'd3;
    localparam rpt_reg_idx_t REG_TRANS_Y  = 3'd4;
    localparam rpt_reg_idx_t REG_TRANS_Z  = 3'd5;

    typedef logic [1:0] rpt_class_t;

    localparam rpt_class_t CLS_INVALID   = 2'd0;
    localparam rpt_class_t CLS_TRANSFORM = 2'd1;
    localparam rpt_class_t CLS_MAX_RANGE = 2'd2;
    localparam rpt_class_t CLS_VIEWPOINT = 2'd3;

    localparam logic [2:0] FIN_ALL  = 3'b111;
    localparam logic [2:0] FIN_YZ   = 3'b110;
    localparam logic [2:0] FIN_NONE = 3'b000;

    // Side information that rides along with the arithmetic.
    typedef struct packed {
        rpt_class_t           cls;
        logic [2:0]           fin;
        logic [FIELD_W-1:0]   x;
        logic [FIELD_W-1:0]   y;
        logic [FIELD_W-1:0]   z;
        logic [FIELD_W-1:0]   distance;
    } rpt_meta_t;

endpackage

### src/rigid_point_transform.sv
`timescale 1ns / 1ps

// Rigid point transform: out = R * p + t per point, Q16.16 coordinates and
// Q2.14 rotation entries, rounded half up and saturated. One beat is accepted
// on every clock (busy stays low); its result is presented with done once it
// has passed through four register stages:
// input capture, the nine 32-bit by coefficient products, the row sums, and
// the translation add with saturation. The result is held for one cycle only
// and the receiver cannot stall it. Rotation rows sit at byte addresses 0, 8
// and 16 and translations at 24, 32 and 40 on the 64-bit register port; write
// them only while no beats are in flight.
`include "rigid_point_transform_assert.svh"

module rigid_point_transform
    import rpt_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int COEF_WIDTH  = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready,

    input  logic                      start,
    output logic                      busy,
    input  logic                      req_type,
    input  logic signed [FIELD_W-1:0] in_x,
    input  logic signed [FIELD_W-1:0] in_y,
    input  logic signed [FIELD_W-1:0] in_z,
    input  logic [2:0]                coord_finite,
    input  logic signed [FIELD_W-1:0] in_distance,
    input  logic                      distance_ok,

    output logic                      done,
    output logic signed [FIELD_W-1:0] out_x,
    output logic signed [FIELD_W-1:0] out_y,
    output logic signed [FIELD_W-1:0] out_z,
    output logic [2:0]                out_finite,
    output logic signed [FIELD_W-1:0] out_distance,
    output logic [1:0]                point_class,
    output logic                      saturated
);

    localparam int CW        = COEF_WIDTH;
    localparam int FRAC      = COEF_WIDTH - 2;
    localparam int ROW_EXT_W = (3 * CW > CFG_W) ? 3 * CW : CFG_W;
    localparam int PROD_W    = FIELD_W + CW;
    localparam int SUM_W     = PROD_W + 2;
    localparam int SHIFT_W   = SUM_W - FRAC;
    localparam int RES_W     = SHIFT_W + 1;
    localparam int CMP_W     = ((RES_W > COORD_WIDTH) ? RES_W : COORD_WIDTH) + 1;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC - 1);
    localparam logic signed [CMP_W-1:0] SAT_HI =
        signed'({{(CMP_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}});
    localparam logic signed [CMP_W-1:0] SAT_LO = ~SAT_HI;

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]          rot_reg   [3];
    logic signed [FIELD_W-1:0] trans_reg [3];
    logic                      wr_en;
    rpt_reg_idx_t              reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                rot_reg[r]   <= CFG_W'(ROW_EXT_W'(1) << (FRAC + r * CW));
                trans_reg[r] <= '0;
            end
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_ROT_ROW0: rot_reg[0]   <= pwdata[CFG_W-1:0];
                REG_ROT_ROW1: rot_reg[1]   <= pwdata[CFG_W-1:0];
                REG_ROT_ROW2: rot_reg[2]   <= pwdata[CFG_W-1:0];
                REG_TRANS_X:  trans_reg[0] <= signed'(pwdata[FIELD_W-1:0]);
                REG_TRANS_Y:  trans_reg[1] <= signed'(pwdata[FIELD_W-1:0]);
                REG_TRANS_Z:  trans_reg[2] <= signed'(pwdata[FIELD_W-1:0]);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ROT_ROW0: prdata = DATA_W'(rot_reg[0]);
            REG_ROT_ROW1: prdata = DATA_W'(rot_reg[1]);
            REG_ROT_ROW2: prdata = DATA_W'(rot_reg[2]);
            REG_TRANS_X:  prdata = DATA_W'(unsigned'(trans_reg[0]));
            REG_TRANS_Y:  prdata = DATA_W'(unsigned'(trans_reg[1]));
            REG_TRANS_Z:  prdata = DATA_W'(unsigned'(trans_reg[2]));
            default:      prdata = '0;
        endcase
    end

    // Coefficients beyond the 48 stored bits read as zero.
    logic [ROW_EXT_W-1:0]   row_ext [3];
    logic signed [CW-1:0]   coef    [3][3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            row_ext[r] = ROW_EXT_W'(rot_reg[r]);
            for (int c = 0; c < 3; c++)
            begin
                coef[r][c] = signed'(row_ext[r][c * CW +: CW]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: classify and pick operands
    // ------------------------------------------------------------------
    logic                      accept;
    rpt_meta_t                 s1_meta_next;
    logic signed [FIELD_W-1:0] s1_opx_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        s1_meta_next.x        = in_x;
        s1_meta_next.y        = in_y;
        s1_meta_next.z        = in_z;
        s1_meta_next.distance = in_distance;
        s1_opx_next           = in_x;
        if (req_type)
        begin
            s1_meta_next.cls = CLS_VIEWPOINT;
            s1_meta_next.fin = (coord_finite == FIN_ALL) ? FIN_ALL : FIN_NONE;
        end
        else if (coord_finite == FIN_ALL)
        begin
            s1_meta_next.cls = CLS_TRANSFORM;
            s1_meta_next.fin = FIN_ALL;
        end
        else if (!distance_ok)
        begin
            s1_meta_next.cls = CLS_INVALID;
            s1_meta_next.fin = coord_finite;
        end
        else
        begin
            // Max-range point: the saved distance stands in for x.
            s1_meta_next.cls = CLS_MAX_RANGE;
            s1_meta_next.fin = ((coord_finite & FIN_YZ) == FIN_YZ) ? FIN_YZ : FIN_NONE;
            s1_opx_next      = in_distance;
        end
    end

    logic                      s1_valid_reg;
    rpt_meta_t                 s1_meta_reg;
    logic signed [FIELD_W-1:0] s1_opnd_reg [3];

    logic                      s2_valid_reg;
    rpt_meta_t                 s2_meta_reg;
    logic signed [PROD_W-1:0]  s2_prod_reg [3][3];

    logic                      s3_valid_reg;
    rpt_meta_t                 s3_meta_reg;
    logic signed [SUM_W-1:0]   s3_sum_reg  [3];

    logic                      s4_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_meta_reg    <= s1_meta_next;
            s1_opnd_reg[0] <= s1_opx_next;
            s1_opnd_reg[1] <= in_y;
            s1_opnd_reg[2] <= in_z;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: nine products
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_meta_reg <= s1_meta_reg;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    s2_prod_reg[r][c] <= PROD_W'(s1_opnd_reg[c]) * PROD_W'(coef[r][c]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: row sums with the rounding half folded in
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            s3_meta_reg <= s2_meta_reg;
            for (int r = 0; r < 3; r++)
            begin
                s3_sum_reg[r] <= SUM_W'(s2_prod_reg[r][0]) + SUM_W'(s2_prod_reg[r][1])
                               + SUM_W'(s2_prod_reg[r][2]) + ROUND_HALF;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: scale, translate, saturate, select the result
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0]   shifted [3];
    logic signed [RES_W-1:0]   row_res [3];
    logic signed [CMP_W-1:0]   row_ext_res [3];
    logic signed [CMP_W-1:0]   row_clip [3];
    logic [2:0]                row_sat;
    logic [FIELD_W-1:0]        row_out [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            shifted[r]     = s3_sum_reg[r] >>> FRAC;
            row_res[r]     = RES_W'(signed'(shifted[r][SHIFT_W-1:0])) + RES_W'(trans_reg[r]);
            row_ext_res[r] = CMP_W'(row_res[r]);
            if (row_ext_res[r] > SAT_HI)
            begin
                row_clip[r] = SAT_HI;
                row_sat[r]  = 1'b1;
            end
            else if (row_ext_res[r] < SAT_LO)
            begin
                row_clip[r] = SAT_LO;
                row_sat[r]  = 1'b1;
            end
            else
            begin
                row_clip[r] = row_ext_res[r];
                row_sat[r]  = 1'b0;
            end
            row_out[r] = row_clip[r][FIELD_W-1:0];
        end
    end

    logic [FIELD_W-1:0] out_x_next;
    logic [FIELD_W-1:0] out_y_next;
    logic [FIELD_W-1:0] out_z_next;
    logic [FIELD_W-1:0] out_dist_next;
    logic               sat_next;

    always_comb
    begin
        out_x_next    = row_out[0];
        out_y_next    = row_out[1];
        out_z_next    = row_out[2];
        out_dist_next = s3_meta_reg.distance;
        sat_next      = |row_sat;
        case (s3_meta_reg.cls)
            CLS_INVALID:
            begin
                out_x_next = s3_meta_reg.x;
                out_y_next = s3_meta_reg.y;
                out_z_next = s3_meta_reg.z;
                sat_next   = 1'b0;
            end
            CLS_MAX_RANGE:
            begin
                out_x_next    = '0;
                out_dist_next = row_out[0];
            end
            default: ;
        endcase
    end

    logic [FIELD_W-1:0] out_x_reg;
    logic [FIELD_W-1:0] out_y_reg;
    logic [FIELD_W-1:0] out_z_reg;
    logic [FIELD_W-1:0] out_dist_reg;
    logic [2:0]         out_fin_reg;
    rpt_class_t         out_cls_reg;
    logic               out_sat_reg;

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            out_x_reg    <= out_x_next;
            out_y_reg    <= out_y_next;
            out_z_reg    <= out_z_next;
            out_dist_reg <= out_dist_next;
            out_fin_reg  <= s3_meta_reg.fin;
            out_cls_reg  <= s3_meta_reg.cls;
            out_sat_reg  <= sat_next;
        end
    end

    assign done         = s4_valid_reg;
    assign out_x        = signed'(out_x_reg);
    assign out_y        = signed'(out_y_reg);
    assign out_z        = signed'(out_z_reg);
    assign out_distance = signed'(out_dist_reg);
    assign out_finite   = out_fin_reg;
    assign point_class  = out_cls_reg;
    assign saturated    = out_sat_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `RPT_ASSERT_SAME(a_done_latency, done, $past(start && !busy, 4))
    `RPT_ASSERT_SAME(a_view_class, done && (point_class == CLS_VIEWPOINT), $past(req_type, 4))
    `RPT_ASSERT_SAME(a_invalid_passthru, done && (point_class == CLS_INVALID), (!saturated) && (out_x == $past(in_x, 4)) && (out_finite == $past(coord_finite, 4)))
    `RPT_ASSERT_NEXT(a_trans_x_write, wr_en && (reg_idx == REG_TRANS_X), trans_reg[0] == signed'($past(pwdata[FIELD_W-1:0])))

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import rpt_pkg::*;

    localparam logic REQ_CLOUD = 1'b0;
    localparam logic REQ_VIEW  = 1'b1;

    typedef struct packed {
        logic        req;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [2:0]  fin;
        logic [31:0] distance;
        logic        dok;
    } point_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [2:0]  fin;
        logic [31:0] distance;
        rpt_class_t  cls;
        logic        sat;
    } point_out_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [ADDR_W-1:0]         paddr = '0;
    logic [DATA_W-1:0]         pwdata = '0;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      req_type;
    logic signed [FIELD_W-1:0] in_x;
    logic signed [FIELD_W-1:0] in_y;
    logic signed [FIELD_W-1:0] in_z;
    logic [2:0]                coord_finite;
    logic signed [FIELD_W-1:0] in_distance;
    logic                      distance_ok;
    logic                      done;
    logic signed [FIELD_W-1:0] out_x;
    logic signed [FIELD_W-1:0] out_y;
    logic signed [FIELD_W-1:0] out_z;
    logic [2:0]                out_finite;
    logic signed [FIELD_W-1:0] out_distance;
    logic [1:0]                point_class;
    logic                      saturated;

    point_t     cur_point = '0;
    logic       beat_taken = 1'b0;
    int         idle_pct = 10;
    int         mismatches = 0;
    point_t     pending_points[$];
    point_out_t expected_points[$];

    // Shadow copy of the register file, as it is after reset.
    logic [47:0] rot_rows[3] = '{48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000};
    logic [31:0] trans_vals[3] = '{32'h0, 32'h0, 32'h0};

    assign req_type     = cur_point.req;
    assign in_x         = cur_point.x;
    assign in_y         = cur_point.y;
    assign in_z         = cur_point.z;
    assign coord_finite = cur_point.fin;
    assign in_distance  = cur_point.distance;
    assign distance_ok  = cur_point.dok;

    rigid_point_transform dut (.*);

    always #2 clk = ~clk;

    // Returns the clip flag above the 32-bit coordinate.
    function automatic logic [32:0] row_eval(input logic [47:0] row, input logic [31:0] tr,
                                             input longint px, input longint py,
                                             input longint pz);
        longint acc;
        longint v;
        acc = px * longint'($signed(row[15:0])) + py * longint'($signed(row[31:16]))
            + pz * longint'($signed(row[47:32]));
        v = ((acc + 64'sd8192) >>> 14) + longint'($signed(tr));
        if (v > 64'sd2147483647)
            return {1'b1, 32'h7FFF_FFFF};
        if (v < -64'sd2147483648)
            return {1'b1, 32'h8000_0000};
        return {1'b0, v[31:0]};
    endfunction

    function automatic point_out_t transform_point(input point_t p);
        point_out_t  r;
        logic [32:0] v0;
        logic [32:0] v1;
        logic [32:0] v2;
        longint      px;
        longint      py;
        longint      pz;
        r.x        = p.x;
        r.y        = p.y;
        r.z        = p.z;
        r.fin      = p.fin;
        r.distance = p.distance;
        r.sat      = 1'b0;
        py = longint'($signed(p.y));
        pz = longint'($signed(p.z));
        // A max-range point is transformed with its distance standing in for x.
        px = (p.req == REQ_VIEW || p.fin == FIN_ALL || !p.dok) ? longint'($signed(p.x))
                                                              : longint'($signed(p.distance));
        v0 = row_eval(rot_rows[0], trans_vals[0], px, py, pz);
        v1 = row_eval(rot_rows[1], trans_vals[1], px, py, pz);
        v2 = row_eval(rot_rows[2], trans_vals[2], px, py, pz);
        if (p.req == REQ_VIEW || p.fin == FIN_ALL) begin
            r.x   = v0[31:0];
            r.y   = v1[31:0];
            r.z   = v2[31:0];
            r.sat = v0[32] | v1[32] | v2[32];
            if (p.req == REQ_VIEW) begin
                r.cls = CLS_VIEWPOINT;
                r.fin = (p.fin == FIN_ALL) ? FIN_ALL : FIN_NONE;
            end
            else begin
                r.cls = CLS_TRANSFORM;
                r.fin = FIN_ALL;
            end
        end
        else if (!p.dok) begin
            r.cls = CLS_INVALID;
        end
        else begin
            r.x        = '0;
            r.distance = v0[31:0];
            r.y        = v1[31:0];
            r.z        = v2[31:0];
            r.sat      = v0[32] | v1[32] | v2[32];
            r.fin      = ((p.fin & FIN_YZ) == FIN_YZ) ? FIN_YZ : FIN_NONE;
            r.cls      = CLS_MAX_RANGE;
        end
        return r;
    endfunction

    function automatic point_t mk_point(input logic req, input logic [31:0] x,
                                        input logic [31:0] y, input logic [31:0] z,
                                        input logic [2:0] fin, input logic [31:0] distance,
                                        input logic dok);
        point_t p;
        p.req      = req;
        p.x        = x;
        p.y        = y;
        p.z        = z;
        p.fin      = fin;
        p.distance = distance;
        p.dok      = dok;
        return p;
    endfunction

    function automatic logic [31:0] rand_coord();
        logic [31:0] v;
        case ($urandom_range(3))
            0: v = 32'($signed(21'($urandom)));
            1: case ($urandom_range(3))
                   0: v = 32'h7FFF_FFFF;
                   1: v = 32'h8000_0000;
                   2: v = 32'h0;
                   default: v = 32'hFFFF_FFFF;
               endcase
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic point_t random_point();
        point_t p;
        p.req      = ($urandom_range(3) == 0) ? REQ_VIEW : REQ_CLOUD;
        p.x        = rand_coord();
        p.y        = rand_coord();
        p.z        = rand_coord();
        p.fin      = $urandom_range(1) ? FIN_ALL : 3'($urandom_range(7));
        p.distance = rand_coord();
        p.dok      = 1'($urandom_range(1));
        return p;
    endfunction

    // Entries of unit, negative unit or zero value, or small random cross terms.
    function automatic logic [47:0] unit_row();
        logic [15:0] c[3];
        for (int i = 0; i < 3; i++) begin
            case ($urandom_range(3))
                0: c[i] = 16'h4000;
                1: c[i] = 16'hC000;
                2: c[i] = 16'h0000;
                default: c[i] = 16'($signed(12'($urandom)));
            endcase
        end
        return {c[2], c[1], c[0]};
    endfunction

    task automatic write_reg(input rpt_reg_idx_t idx, input logic [63:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_ROT_ROW0: rot_rows[0] = val[47:0];
            REG_ROT_ROW1: rot_rows[1] = val[47:0];
            REG_ROT_ROW2: rot_rows[2] = val[47:0];
            REG_TRANS_X:  trans_vals[0] = val[31:0];
            REG_TRANS_Y:  trans_vals[1] = val[31:0];
            REG_TRANS_Z:  trans_vals[2] = val[31:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_transform(input logic [47:0] r0, input logic [47:0] r1,
                                  input logic [47:0] r2, input logic [31:0] tx,
                                  input logic [31:0] ty, input logic [31:0] tz);
        write_reg(REG_ROT_ROW0, {16'h0, r0});
        write_reg(REG_ROT_ROW1, {16'h0, r1});
        write_reg(REG_ROT_ROW2, {16'h0, r2});
        write_reg(REG_TRANS_X, {32'h0, tx});
        write_reg(REG_TRANS_Y, {32'h0, ty});
        write_reg(REG_TRANS_Z, {32'h0, tz});
    endtask

    // Returns once every queued beat has been taken and every result checked.
    task automatic drain();
        while (pending_points.size() != 0 || start || expected_points.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(negedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end
        else if (!start || beat_taken) begin
            if (pending_points.size() != 0 && $urandom_range(99) >= idle_pct) begin
                cur_point <= pending_points.pop_front();
                start     <= 1'b1;
            end
            else begin
                // Junk on the payload while idle must be ignored.
                cur_point <= random_point();
                start     <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin : monitor
        point_out_t want;
        if (!rst_n) begin
            beat_taken <= 1'b0;
        end
        else begin
            beat_taken <= start && !busy;
            if (start && !busy)
                expected_points.push_back(transform_point(cur_point));
            if (done) begin
                if (expected_points.size() == 0) begin
                    $display("%0t: result beat with nothing expected, got x %h y %h z %h",
                             $time, out_x, out_y, out_z);
                    mismatches++;
                end
                else begin
                    want = expected_points.pop_front();
                    check_field("out_x", want.x, out_x);
                    check_field("out_y", want.y, out_y);
                    check_field("out_z", want.z, out_z);
                    check_field("out_finite", 32'(want.fin), 32'(out_finite));
                    check_field("out_distance", want.distance, out_distance);
                    check_field("point_class", 32'(want.cls), 32'(point_class));
                    check_field("saturated", 32'(want.sat), 32'(saturated));
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Identity transform after reset: every case and the coordinate extremes.
        pending_points.push_back(mk_point(REQ_CLOUD, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                          32'h7FFF_FFFF, FIN_ALL, 32'h0, 1'b0));
        pending_points.push_back(mk_point(REQ_CLOUD, 32'h8000_0000, 32'h8000_0000,
                                          32'h8000_0000, FIN_ALL, 32'h0, 1'b0));
        pending_points.push_back(mk_point(REQ_CLOUD, 32'h0, 32'h0, 32'h0, FIN_ALL,
                                          32'hFFFF_FFFF, 1'b1));
        pending_points.push_back(mk_point(REQ_CLOUD, 32'hFFFF_FFFF, 32'h1, 32'h0001_0000,
                                          FIN_ALL, 32'h7FFF_FFFF, 1'b0));
        pending_points.push_back(mk_point(REQ_CLOUD, 32'h1234_5678, 32'h8000_0000,
                                          32'h7FFF_FFFF, FIN_NONE, 32'h5555_AAAA, 1'b0));
        pending_points.push_back(mk_point(REQ_CLOUD, 32'h7FFF_FFFF, 32'h8000_0000,
                                          32'hFFFF_FFFF, FIN_YZ, 32'h8000_0000, 1'b0));
        pending_points.push_back(mk_point(REQ_CLOUD, 32'hDEAD_BEEF, 32'h1, 32'h2,
                                          3'b011, 32'h0, 1'b0));
        pending_points.push_back(mk_point(REQ_CLOUD, 32'h7FFF_FFFF, 32'h0002_0000,
                                          32'hFFFE_0000, FIN_YZ, 32'h0005_8000, 1'b1));
        pending_points.push_back(mk_point(REQ_CLOUD, 32'h8000_0000, 32'h8000_0000,
                                          32'h7FFF_FFFF, FIN_NONE, 32'h7FFF_FFFF, 1'b1));
        pending_points.push_back(mk_point(REQ_CLOUD, 32'h0, 32'h7FFF_FFFF, 32'h0,
                                          3'b010, 32'h8000_0000, 1'b1));
        pending_points.push_back(mk_point(REQ_CLOUD, 32'h1, 32'h0, 32'h8000_0000,
                                          3'b101, 32'hFFFF_FFFF, 1'b1));
        pending_points.push_back(mk_point(REQ_VIEW, 32'h0003_0000, 32'hFFFD_0000,
                                          32'h0000_8000, FIN_ALL, 32'h0, 1'b0));
        pending_points.push_back(mk_point(REQ_VIEW, 32'h7FFF_FFFF, 32'h8000_0000,
                                          32'h0, FIN_NONE, 32'h1234_0000, 1'b1));
        pending_points.push_back(mk_point(REQ_VIEW, 32'h8000_0000, 32'h7FFF_FFFF,
                                          32'hFFFF_FFFF, 3'b101, 32'h0, 1'b0));
        pending_points.push_back(mk_point(REQ_CLOUD, 32'h0010_0000, 32'hFFF0_0000,
                                          32'h0000_0001, FIN_ALL, 32'h7FFF_FFFF, 1'b1));
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            idle_pct = 10;
            case (ph)
                0: load_transform({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}},
                                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
                1: load_transform({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
                                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
                2: begin
                    load_transform(unit_row(), unit_row(), unit_row(),
                                   32'($signed(24'($urandom))), 32'($signed(24'($urandom))),
                                   32'($signed(24'($urandom))));
                    // A long stretch of back-to-back beats.
                    idle_pct = 0;
                end
                3: load_transform(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                                  48'({$urandom, $urandom}), $urandom, $urandom, $urandom);
                default: load_transform(48'h0, 48'h0, 48'h0, $urandom, $urandom, $urandom);
            endcase
            if (ph < 2) begin
                pending_points.push_back(mk_point(REQ_CLOUD, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                                  32'h7FFF_FFFF, FIN_ALL, 32'h0, 1'b0));
                pending_points.push_back(mk_point(REQ_CLOUD, 32'h8000_0000, 32'h8000_0000,
                                                  32'h8000_0000, FIN_ALL, 32'h0, 1'b0));
                pending_points.push_back(mk_point(REQ_CLOUD, 32'h0, 32'h0, 32'h0,
                                                  FIN_ALL, 32'h0, 1'b0));
                pending_points.push_back(mk_point(REQ_CLOUD, 32'h0, 32'h8000_0000,
                                                  32'h7FFF_FFFF, FIN_YZ, 32'h7FFF_FFFF, 1'b1));
                pending_points.push_back(mk_point(REQ_VIEW, 32'h8000_0000, 32'h7FFF_FFFF,
                                                  32'h8000_0000, FIN_NONE, 32'h0, 1'b0));
            end
            for (int i = 0; i < 100; i++)
                pending_points.push_back(random_point());
            drain();
        end

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
